>>> hw/rtl/grid_dda_ray_column_cast_assert.svh
// Assertion macros for the grid DDA ray caster.
// Included by modules that assert; no other dependencies.
`ifndef GRID_DDA_RAY_COLUMN_CAST_ASSERT_SVH
`define GRID_DDA_RAY_COLUMN_CAST_ASSERT_SVH
`ifndef SYNTHESIS
`define GDR_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");
`define GDR_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GDR_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define GDR_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

>>> hw/rtl/gdda_pkg.sv
// Package for the grid DDA ray caster: payload structs, states, constants.
// No dependencies.
package gdda_pkg;
  localparam int unsigned MAP_DIM_D     = 32;
  localparam int unsigned VIEW_HEIGHT_D = 64;
  localparam int unsigned TEX_SIZE_D    = 32;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  localparam logic [1:0] REG_CAMERA_X = 2'd0;
  localparam logic [1:0] REG_CAMERA_Y = 2'd1;

  typedef struct packed {
    logic               opcode;
    logic [4:0]         cell_col;
    logic [4:0]         cell_row;
    logic [2:0]         cell_code;
    logic signed [15:0] ray_x;
    logic signed [15:0] ray_y;
    logic [13:0]        step_len_x;
    logic [13:0]        step_len_y;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         hit_col;
    logic [4:0]         hit_row;
    logic               hit_side;
    logic [3:0]         texture_id;
    logic signed [15:0] perp_dist;
    logic [7:0]         wall_height;
    logic [5:0]         draw_top;
    logic [6:0]         draw_bottom;
    logic [4:0]         tex_column;
    logic               no_hit;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_SETUP, ST_READ, ST_TEST, ST_DIST,
    ST_DIV, ST_FRAC, ST_FIN, ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clr_step;
    logic setup;
    logic walk;
    logic calc_dist;
    logic div_start;
    logic div_step;
    logic frac;
    logic fin;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_cast;
    logic clr_done;
    logic outside;
    logic hit;
    logic div_need;
    logic div_done;
  } sts_t;
endpackage

>>> hw/rtl/gdda_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module gdda_ram #(
  parameter int unsigned WIDTH = 3,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write one entry, read one entry
  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata_r <= mem_r[raddr];
  end
  assign rdata = rdata_r;
endmodule

>>> hw/rtl/gdda_ctrl.sv
// Sequencer for the grid DDA ray caster: clear pass, walk, divide, emit.
// Depends on gdda_pkg and the assertion header.
`include "grid_dda_ray_column_cast_assert.svh"
module gdda_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  gdda_pkg::sts_t  sts,
  output gdda_pkg::cmd_t  cmd,
  output logic            busy
);
  import gdda_pkg::*;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = sts.is_cast ? ST_SETUP : ST_IDLE;
      ST_CLEAR: if (sts.clr_done) state_nxt = ST_IDLE;
      ST_SETUP: state_nxt = ST_READ;
      ST_READ:  state_nxt = sts.outside ? ST_EMIT : ST_TEST;
      ST_TEST:  state_nxt = sts.hit ? ST_DIST : ST_READ;
      ST_DIST:  state_nxt = ST_DIV;
      ST_DIV:   if (!sts.div_need || sts.div_done) state_nxt = ST_FRAC;
      ST_FRAC:  state_nxt = ST_FIN;
      ST_FIN:   state_nxt = ST_EMIT;
      ST_EMIT:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE:  begin busy = 1'b0; cmd.load = start; end
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_SETUP: cmd.setup = 1'b1;
      ST_READ:  ;
      ST_TEST:  cmd.walk = !sts.hit;
      ST_DIST:  begin cmd.calc_dist = 1'b1; end
      ST_DIV:   begin cmd.div_start = 1'b0; cmd.div_step = 1'b1; end
      ST_FRAC:  cmd.frac = 1'b1;
      ST_FIN:   cmd.fin = 1'b1;
      ST_EMIT:  cmd.emit = 1'b1;
      default:  ;
    endcase
    if (state_r == ST_DIST) cmd.div_start = 1'b1;
  end

  `GDR_ASSERT_NXT(a_setup_read, clk, rst_n, state_r == ST_SETUP, state_r == ST_READ)
  `GDR_ASSERT_NXT(a_emit_idle, clk, rst_n, cmd.emit, !busy)
  `GDR_ASSERT_IMP(a_no_load_busy, clk, rst_n, cmd.load, !busy)
endmodule

>>> hw/rtl/gdda_dp.sv
// Datapath for the grid DDA ray caster: map RAM, DDA walk, divider, outputs.
// Depends on gdda_pkg and gdda_ram.
module gdda_dp #(
  parameter int unsigned MAP_DIM     = gdda_pkg::MAP_DIM_D,
  parameter int unsigned VIEW_HEIGHT = gdda_pkg::VIEW_HEIGHT_D,
  parameter int unsigned TEX_SIZE    = gdda_pkg::TEX_SIZE_D
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gdda_pkg::in_item_t  in_item,
  input  logic [11:0]         cam_x,
  input  logic [11:0]         cam_y,
  input  gdda_pkg::cmd_t      cmd,
  output gdda_pkg::sts_t      sts,
  output gdda_pkg::out_item_t out_item,
  output logic                out_valid
);
  import gdda_pkg::*;
  localparam int unsigned AW = $clog2(MAP_DIM);
  localparam int unsigned DEPTH = MAP_DIM * MAP_DIM;
  localparam int unsigned DW = $clog2(DEPTH);
  localparam int unsigned TW = $clog2(TEX_SIZE);
  localparam logic [15:0] HNUM = 16'(VIEW_HEIGHT * 128);
  localparam logic [7:0] VH = 8'(VIEW_HEIGHT);
  localparam logic [7:0] VH2 = 8'(VIEW_HEIGHT / 2);

  // map position is kept signed and wide enough to step outside
  logic signed [9:0]  mx_r, my_r;
  logic signed [31:0] sdx_r, sdy_r;
  logic [13:0]        dx_r, dy_r;
  logic signed [15:0] rdx_r, rdy_r;
  logic               side_r;
  logic [2:0]         code_r;
  logic signed [15:0] dist_r;
  logic [DW:0]        clr_r;
  logic [15:0]        rem_r, quo_r;
  logic [4:0]         dcnt_r;
  logic [7:0]         height_r;
  logic signed [31:0] prod_r;
  out_item_t          res_r;
  logic               vld_r;

  logic               we;
  logic [DW-1:0]      waddr, raddr;
  logic [2:0]         wdata, rdata;
  logic               outside;

  // clear pass then item writes
  always_comb begin
    we = 1'b0;
    waddr = clr_r[DW-1:0];
    wdata = '0;
    if (cmd.clr_step) we = 1'b1;
    else if (cmd.load && in_item.opcode == OP_WRITE &&
             32'(in_item.cell_col) < MAP_DIM && 32'(in_item.cell_row) < MAP_DIM) begin
      we = 1'b1;
      waddr = DW'(32'(in_item.cell_col) * MAP_DIM + 32'(in_item.cell_row));
      wdata = in_item.cell_code;
    end
  end
  assign raddr = DW'(32'(unsigned'(mx_r[AW-1:0])) * MAP_DIM + 32'(unsigned'(my_r[AW-1:0])));

  gdda_ram #(.WIDTH(3), .DEPTH(DEPTH)) u_map (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign outside = mx_r < 0 || my_r < 0 || 32'(mx_r) >= MAP_DIM || 32'(my_r) >= MAP_DIM;

  logic signed [31:0] dist_w, dist_sel;
  assign dist_sel = side_r ? (sdy_r - 32'(dy_r)) : (sdx_r - 32'(dx_r));
  assign dist_w = dist_sel > 32767 ? 32'sd32767 :
                  (dist_sel < -32768 ? -32'sd32768 : dist_sel);

  logic [16:0] trial;
  assign trial = {rem_r, quo_r[15]} - {1'b0, dist_r};

  logic [6:0] fx, fy;
  logic [6:0] frac;
  logic [TW+6:0] texp;
  logic [TW-1:0] tex;
  logic [8:0]  hhalf;
  logic [8:0]  top_w, bot_w;
  assign fx = cam_x[6:0];
  assign fy = cam_y[6:0];
  assign frac = (side_r ? fx : fy) + prod_r[13:7];
  assign texp = (TW+7)'(frac) * (TW+7)'(TEX_SIZE);
  assign tex = texp[TW+6:7];
  assign hhalf = (9'(height_r) + 9'd1) >> 1;
  assign top_w = (9'(VH2) > hhalf) ? 9'(VH2) - hhalf : 9'd0;
  assign bot_w = (top_w + 9'(height_r) > 9'(VH)) ? 9'(VH) : top_w + 9'(height_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      vld_r <= 1'b0;
      dcnt_r <= '0;
    end else begin
      vld_r <= cmd.emit;
      if (cmd.clr_step) clr_r <= clr_r + 1'b1;
      // latch a cast
      if (cmd.load) begin
        rdx_r <= in_item.ray_x;
        rdy_r <= in_item.ray_y;
        dx_r <= in_item.step_len_x;
        dy_r <= in_item.step_len_y;
        res_r <= '0;
      end
      // first side distances
      if (cmd.setup) begin
        mx_r <= 10'(cam_x[11:7]);
        my_r <= 10'(cam_y[11:7]);
        side_r <= 1'b0;
        sdx_r <= 32'((rdx_r < 0 ? 21'(fx) : 21'(8'd128 - 8'(fx))) * 21'(dx_r)) >>> 7;
        sdy_r <= 32'((rdy_r < 0 ? 21'(fy) : 21'(8'd128 - 8'(fy))) * 21'(dy_r)) >>> 7;
      end
      // advance one cell
      if (cmd.walk) begin
        if (sdx_r < sdy_r) begin
          sdx_r <= sdx_r + 32'(dx_r);
          mx_r <= rdx_r < 0 ? mx_r - 10'sd1 : mx_r + 10'sd1;
          side_r <= 1'b0;
        end else begin
          sdy_r <= sdy_r + 32'(dy_r);
          my_r <= rdy_r < 0 ? my_r - 10'sd1 : my_r + 10'sd1;
          side_r <= 1'b1;
        end
      end
      if (cmd.calc_dist) begin
        code_r <= rdata;
        dist_r <= 16'(dist_w);
      end
      // restoring divide, one quotient bit per cycle
      if (cmd.div_start) begin
        rem_r <= '0;
        quo_r <= HNUM;
        dcnt_r <= '0;
      end else if (cmd.div_step && dist_r > 0 && dcnt_r != 5'd16) begin
        dcnt_r <= dcnt_r + 5'd1;
        if (!trial[16]) begin
          rem_r <= trial[15:0];
          quo_r <= {quo_r[14:0], 1'b1};
        end else begin
          rem_r <= {rem_r[14:0], quo_r[15]};
          quo_r <= {quo_r[14:0], 1'b0};
        end
      end
      if (cmd.frac) begin
        height_r <= dist_r == 0 ? 8'd255 : (dist_r < 0 ? VH :
                    (quo_r > 16'd255 ? 8'd255 : quo_r[7:0]));
        prod_r <= 32'(dist_r) * 32'(side_r ? rdx_r : rdy_r);
      end
      if (cmd.fin) begin
        res_r.hit_col <= 5'(mx_r);
        res_r.hit_row <= 5'(my_r);
        res_r.hit_side <= side_r;
        res_r.texture_id <= 4'((code_r - 3'd1) * 2) + 4'(side_r);
        res_r.perp_dist <= dist_r;
        res_r.wall_height <= height_r;
        res_r.draw_top <= 6'(top_w);
        res_r.draw_bottom <= 7'(bot_w);
        res_r.tex_column <= 5'(((!side_r && rdx_r > 0) || (side_r && rdy_r < 0)) ?
                            TW'(TEX_SIZE - 1) - tex : tex);
        res_r.no_hit <= 1'b0;
      end
      if (cmd.emit && !cmd.fin && res_r == '0 && outside) res_r.no_hit <= 1'b1;
    end
  end

  // emit latches no_hit directly when walk left the map
  always_comb begin
    out_item = res_r;
  end
  assign out_valid = vld_r;

  assign sts.is_cast = in_item.opcode == OP_CAST;
  assign sts.clr_done = clr_r == (DW+1)'(DEPTH - 1);
  assign sts.outside = outside;
  assign sts.hit = rdata != 3'd0;
  assign sts.div_need = dist_r > 0;
  assign sts.div_done = dcnt_r == 5'd16;
endmodule

>>> hw/rtl/grid_dda_ray_column_cast.sv
// Grid DDA ray caster top level: APB camera registers, controller, datapath.
// A cast walks the map one cell per step, at most 63 steps; a hit computes the distance,
// runs the divide only for a distance above zero and forms the column; a miss sets no_hit.
// A write completes at its accept edge and gives no result; one item at a time.
// Results cannot be stalled; busy drops in the strobe cycle. Uses gdda_pkg.
// Reset: a clearing pass writes every map cell empty, busy high.
module grid_dda_ray_column_cast #(
  parameter int unsigned MAP_DIM     = gdda_pkg::MAP_DIM_D,
  parameter int unsigned VIEW_HEIGHT = gdda_pkg::VIEW_HEIGHT_D,
  parameter int unsigned TEX_SIZE    = gdda_pkg::TEX_SIZE_D
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  gdda_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output gdda_pkg::out_item_t out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import gdda_pkg::*;
  logic [11:0] cam_x_r, cam_y_r;
  cmd_t cmd;
  sts_t sts;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  // camera registers, word index in paddr[2]
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0;
      cam_y_r <= '0;
    end else if (wr_en) begin
      if ({1'b0, paddr[2]} == REG_CAMERA_X) cam_x_r <= pwdata[11:0];
      if ({1'b0, paddr[2]} == REG_CAMERA_Y) cam_y_r <= pwdata[11:0];
    end
  end
  assign prdata = ({1'b0, paddr[2]} == REG_CAMERA_X) ? 32'(cam_x_r) : 32'(cam_y_r);

  gdda_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
  );

  gdda_dp #(.MAP_DIM(MAP_DIM), .VIEW_HEIGHT(VIEW_HEIGHT), .TEX_SIZE(TEX_SIZE)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .cam_x(cam_x_r), .cam_y(cam_y_r),
    .cmd(cmd), .sts(sts), .out_item(out_item), .out_valid(out_strobe)
  );
endmodule

>>> tb/grid_dda_ray_column_cast_tb.sv
// Self-checking testbench for the grid DDA ray column caster.
// Depends on gdda_pkg and grid_dda_ray_column_cast; predicts each cast result and compares.
module grid_dda_ray_column_cast_tb;
  import gdda_pkg::*;

  localparam int MAPD = 32;
  localparam int VH   = 64;
  localparam int TS   = 32;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_item;
  logic out_strobe;
  out_item_t out_item;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  grid_dda_ray_column_cast dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [2:0] map_model [MAPD*MAPD];
  logic [11:0] cam_x, cam_y;

  in_item_t pending_items[$];
  out_item_t expected_hits[$];
  int errors;
  int gap_left;
  bit quiet;
  bit drv_active;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // compute one cast result from the model map and camera
  function automatic out_item_t cast_ray(in_item_t it);
    out_item_t r;
    longint rdx, rdy, dx, dy, sdx, sdy, mx, my, stx, sty, pdist, hq, prod, t;
    int fx, fy, side, height, top, bottom, frac, tex, code;
    bit hit;
    r = '0;
    rdx = it.ray_x;
    rdy = it.ray_y;
    dx = it.step_len_x;
    dy = it.step_len_y;
    fx = cam_x[6:0];
    fy = cam_y[6:0];
    mx = cam_x[11:7];
    my = cam_y[11:7];
    if (rdx < 0) begin stx = -1; sdx = (fx * dx) >>> 7; end
    else begin stx = 1; sdx = ((128 - fx) * dx) >>> 7; end
    if (rdy < 0) begin sty = -1; sdy = (fy * dy) >>> 7; end
    else begin sty = 1; sdy = ((128 - fy) * dy) >>> 7; end
    side = 0;
    hit = 0;
    while (mx >= 0 && mx < MAPD && my >= 0 && my < MAPD) begin
      if (map_model[mx*MAPD + my] != 0) begin
        hit = 1;
        break;
      end
      if (sdx < sdy) begin sdx += dx; mx += stx; side = 0; end
      else begin sdy += dy; my += sty; side = 1; end
    end
    if (!hit) begin
      r.no_hit = 1'b1;
      return r;
    end
    pdist = (side == 0) ? sdx - dx : sdy - dy;
    if (pdist > 32767) pdist = 32767;
    if (pdist < -32768) pdist = -32768;
    if (pdist == 0) height = 255;
    else if (pdist < 0) height = VH;
    else begin
      hq = (VH * 128) / pdist;
      height = (hq > 255) ? 255 : int'(hq);
    end
    t = VH / 2 - (height + 1) / 2;
    if (t < 0) t = 0;
    top = int'(t);
    bottom = top + height;
    if (bottom > VH) bottom = VH;
    code = map_model[mx*MAPD + my];
    prod = (side == 0) ? pdist * rdy : pdist * rdx;
    frac = ((side == 0 ? int'(cam_y) : int'(cam_x)) + int'((prod >>> 7) & 64'h7f)) & 8'h7f;
    tex = (frac * TS) >> 7;
    if ((side == 0 && rdx > 0) || (side == 1 && rdy < 0)) tex = TS - 1 - tex;
    r.hit_col = mx[4:0];
    r.hit_row = my[4:0];
    r.hit_side = side[0];
    r.texture_id = 4'((code - 1) * 2 + side);
    r.perp_dist = pdist[15:0];
    r.wall_height = height[7:0];
    r.draw_top = top[5:0];
    r.draw_bottom = bottom[6:0];
    r.tex_column = tex[4:0];
    return r;
  endfunction

  // driver: present queued items with random gaps; predict on transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (start && !busy) begin
      if (in_item.opcode == OP_WRITE) map_model[in_item.cell_col*MAPD + in_item.cell_row] =
          in_item.cell_code;
      else expected_hits.push_back(cast_ray(in_item));
      void'(pending_items.pop_front());
      if (!quiet && $urandom_range(0, 7) == 0) begin
        start <= 1'b0;
        gap_left <= $urandom_range(1, 18);
      end else if (drv_active && pending_items.size() > 0) begin
        in_item <= pending_items[0];
      end else begin
        start <= 1'b0;
      end
    end else if (!start) begin
      if (gap_left > 0) gap_left <= gap_left - 1;
      else if (drv_active && pending_items.size() > 0) begin
        start <= 1'b1;
        in_item <= pending_items[0];
      end
    end
  end

  // monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_strobe) begin
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_item);
        errors++;
      end else begin
        e = expected_hits.pop_front();
        if (e.hit_col !== out_item.hit_col || e.hit_row !== out_item.hit_row ||
            e.hit_side !== out_item.hit_side || e.texture_id !== out_item.texture_id ||
            e.perp_dist !== out_item.perp_dist || e.wall_height !== out_item.wall_height ||
            e.draw_top !== out_item.draw_top || e.draw_bottom !== out_item.draw_bottom ||
            e.tex_column !== out_item.tex_column || e.no_hit !== out_item.no_hit) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, out_item);
          errors++;
        end
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [11:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 1'b0} << 1; pwdata <= {20'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_CAMERA_X) cam_x = val; else cam_y = val;
  endtask

  function automatic in_item_t cell_write(int c, int r, int code);
    in_item_t it;
    it = '0;
    it.opcode = OP_WRITE;
    it.cell_col = c[4:0]; it.cell_row = r[4:0]; it.cell_code = code[2:0];
    it.ray_x = 16'($urandom); it.ray_y = 16'($urandom);
    return it;
  endfunction

  function automatic in_item_t random_cast();
    in_item_t it;
    it = '0;
    it.opcode = OP_CAST;
    it.cell_col = 5'($urandom); it.cell_row = 5'($urandom); it.cell_code = 3'($urandom);
    case ($urandom_range(0, 3))
      0: begin it.ray_x = 16'($urandom); it.ray_y = 16'($urandom); end
      default: begin
        it.ray_x = 16'($signed($urandom_range(0, 512)) - 256);
        it.ray_y = 16'($signed($urandom_range(0, 512)) - 256);
      end
    endcase
    if ($urandom_range(0, 9) == 0) it.step_len_x = 14'($urandom_range(0, 16383));
    else it.step_len_x = 14'($urandom_range(0, 2000));
    if ($urandom_range(0, 9) == 0) it.step_len_y = 14'($urandom_range(0, 16383));
    else it.step_len_y = 14'($urandom_range(0, 2000));
    return it;
  endfunction

  // wait until every queued transfer is done and every result has come
  task automatic drain();
    drv_active = 1'b1;
    while (pending_items.size() > 0 || expected_hits.size() > 0 || start || busy)
      @(posedge clk);
    repeat (200) @(posedge clk);
    drv_active = 1'b0;
  endtask

  initial begin
    in_item_t it;
    int n;
    errors = 0; quiet = 0; drv_active = 0;
    cam_x = '0; cam_y = '0;
    foreach (map_model[i]) map_model[i] = '0;
    rst_n = 1'b0; start = 1'b0; in_item = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty map leaves without a hit, then a border wall
    reg_write(REG_CAMERA_X, 12'd0);
    reg_write(REG_CAMERA_Y, 12'd0);
    it = random_cast(); it.ray_x = 16'sh7fff; it.ray_y = -16'sh8000;
    it.step_len_x = 14'd16256; it.step_len_y = 14'd0;
    pending_items.push_back(it);
    for (int i = 0; i < MAPD; i++) begin
      pending_items.push_back(cell_write(i, 0, 7));
      pending_items.push_back(cell_write(i, 31, 1 + i % 7));
      pending_items.push_back(cell_write(0, i, 3));
      pending_items.push_back(cell_write(31, i, 5));
    end
    drain();
    reg_write(REG_CAMERA_X, 12'd4095);
    reg_write(REG_CAMERA_Y, 12'd4095);
    it = random_cast(); it.ray_x = 0; it.ray_y = 0; it.step_len_x = 0; it.step_len_y = 0;
    pending_items.push_back(it);
    it.ray_x = -16'sh8000; it.ray_y = 16'sh7fff; it.step_len_x = 14'd16256;
    pending_items.push_back(it);
    drain();
    reg_write(REG_CAMERA_X, 12'd2048 + 12'd64);
    reg_write(REG_CAMERA_Y, 12'd2048 + 12'd1);
    for (int i = 0; i < 20; i++) pending_items.push_back(random_cast());
    drain();

    // random phases with fresh camera and map content
    for (int ph = 0; ph < 10; ph++) begin
      reg_write(REG_CAMERA_X, (ph == 9) ? 12'd0 : 12'($urandom_range(128, 3967)));
      reg_write(REG_CAMERA_Y, (ph == 8) ? 12'd4095 : 12'($urandom_range(128, 3967)));
      if (ph == 9) quiet = 1;
      n = 0;
      while (n < 95) begin
        if ($urandom_range(0, 2) == 0) begin
          it = cell_write($urandom_range(0, 31), $urandom_range(0, 31),
                          ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7));
          if ($urandom_range(0, 4) != 0 && it.cell_col[4:0] == cam_x[11:7] &&
              it.cell_row == cam_y[11:7]) it.cell_code = 0;
        end else it = random_cast();
        pending_items.push_back(it);
        n++;
      end
      drain();
    end

    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
